/* src/hhpc_pkg.sv */
`default_nettype none

package hhpc_pkg;

	// cache geometry and payload widths
	localparam int ENTRIES    = 509;
	localparam int PATH_WIDTH = 32;
	localparam int INFO_WIDTH = 64;
	localparam int ID_W       = 64;
	localparam int TS_W       = 32;
	localparam int ACT_W      = 3;

	localparam int SLOT_W = $clog2(ENTRIES);

	// stream widths: fields packed from bit 0 up, rounded to whole bytes
	localparam int S_FIELDS_W = ID_W + TS_W + PATH_WIDTH + INFO_WIDTH;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = INFO_WIDTH + PATH_WIDTH;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	// hash: (HASH_MUL*id + HASH_TS_MUL*sext(ts) + HASH_ADD) mod 2^64, then mod ENTRIES
	localparam logic [ID_W-1:0] HASH_MUL    = 64'd1999;
	localparam logic [ID_W-1:0] HASH_TS_MUL = 64'd3;
	localparam logic [ID_W-1:0] HASH_ADD    = 64'd5;

	// residue unit: sum of 16-bit chunks times 2^(16k) mod ENTRIES, then folding
	localparam int CHUNK_W    = 16;
	localparam int NUM_CHUNKS = ID_W / CHUNK_W;
	localparam int CNT_W      = $clog2(NUM_CHUNKS);
	localparam int ACC_W      = CHUNK_W + SLOT_W + CNT_W;
	localparam int FOLD_A_W   = ACC_W - SLOT_W;
	// 2^SLOT_W mod ENTRIES
	localparam logic [SLOT_W-1:0] FOLD_R = SLOT_W'((1 << SLOT_W) - ENTRIES);

	typedef enum logic [ACT_W-1:0] {
		ACT_STORE_PATH  = 3'd0,
		ACT_UPDATE_INFO = 3'd1,
		ACT_GET_INFO    = 3'd2,
		ACT_GET_PATH    = 3'd3,
		ACT_INVALIDATE  = 3'd4
	} action_t;

	typedef struct packed {
		logic valid;
		logic path_valid;
		logic info_valid;
	} slot_flags_t;

	typedef struct packed {
		logic [ID_W-1:0]       tag_id;
		logic [TS_W-1:0]       tag_ts;
		logic [PATH_WIDTH-1:0] path;
		logic [INFO_WIDTH-1:0] info;
	} slot_data_t;

	typedef struct packed {
		logic              flag_we;
		logic              data_we;
		logic [SLOT_W-1:0] addr;
		slot_flags_t       flags;
	} store_req_t;

	typedef struct packed {
		logic            start;
		logic [ID_W-1:0] id;
		logic [TS_W-1:0] ts;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
	} hash_rsp_t;

	// 2^(CHUNK_W*k) mod ENTRIES, evaluated at elaboration
	function automatic logic [SLOT_W-1:0] fold_weight(input int k);
		logic [SLOT_W:0] w;
		w = (SLOT_W+1)'(1);
		for (int i = 0; i < ID_W; i++) begin
			if (i < k * CHUNK_W) begin
				w = w << 1;
				if (w >= (SLOT_W+1)'(ENTRIES)) begin
					w = w - (SLOT_W+1)'(ENTRIES);
				end
			end
		end
		return w[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/hhpc_hash.sv */
`default_nettype none

module hhpc_hash
	import hhpc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hash_req_t req,
	output hash_rsp_t      rsp
);

	typedef enum logic [2:0] {H_IDLE, H_MUL, H_ADD, H_MAC, H_RED} hstate_t;

	hstate_t           state_q;
	logic [ID_W-1:0]   id_q;
	logic [TS_W-1:0]   ts_q;
	logic [ID_W-1:0]   prod_q;
	logic [ID_W-1:0]   h_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [SLOT_W-1:0] slot_q;

	logic [SLOT_W-1:0]   weight [NUM_CHUNKS];
	logic [ID_W-1:0]     sts;
	logic [FOLD_A_W-1:0] mac_a;
	logic [SLOT_W-1:0]   mac_b;
	logic [ACC_W-1:0]    mac_c;
	logic [ACC_W-1:0]    mac_prod;
	logic [ACC_W-1:0]    mac_sum;
	logic [SLOT_W-1:0]   lo;
	logic                lo_ge;

	for (genvar g = 0; g < NUM_CHUNKS; g++) begin : g_weight
		assign weight[g] = fold_weight(g);
	end

	assign sts = {{(ID_W-TS_W){ts_q[TS_W-1]}}, ts_q};
	assign lo  = acc_q[SLOT_W-1:0];
	assign lo_ge = {1'b0, lo} >= (SLOT_W+1)'(ENTRIES);

	// shared multiply-add: chunk accumulate, then fold hi*R + lo
	always_comb begin
		if (state_q == H_MAC) begin
			mac_a = FOLD_A_W'(h_q[cnt_q*CHUNK_W +: CHUNK_W]);
			mac_b = weight[cnt_q];
			mac_c = acc_q;
		end else begin
			mac_a = acc_q[ACC_W-1:SLOT_W];
			mac_b = FOLD_R;
			mac_c = ACC_W'(lo);
		end
	end

	assign mac_prod = mac_a * mac_b;
	assign mac_sum  = mac_prod + mac_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (req.start) begin
						id_q    <= req.id;
						ts_q    <= req.ts;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					// id * 1999 = id * (2048 - 32 - 16 - 1), wrapping at 64 bits
					prod_q  <= (id_q << 11) - (id_q << 5) - (id_q << 4) - id_q;
					state_q <= H_ADD;
				end
				H_ADD: begin
					// 3 * sext(ts) as a shift and add
					h_q     <= prod_q + (sts << 1) + sts + HASH_ADD;
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= H_MAC;
				end
				H_MAC: begin
					acc_q <= mac_sum;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_CHUNKS-1)) begin
						state_q <= H_RED;
					end
				end
				H_RED: begin
					if (acc_q[ACC_W-1:SLOT_W] != '0) begin
						acc_q <= mac_sum;
					end else begin
						slot_q  <= lo_ge ? lo - SLOT_W'(ENTRIES) : lo;
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.slot = slot_q;

endmodule

`default_nettype wire

/* src/hhpc_store.sv */
`default_nettype none

module hhpc_store
	import hhpc_pkg::*;
(
	input  wire logic       clk,
	input  wire store_req_t req,
	input  wire slot_data_t wr_data,
	output slot_flags_t     rd_flags,
	output slot_data_t      rd_data
);

	// flags are swept clear after reset; tags and payload are gated by them
	slot_flags_t flag_mem [ENTRIES];
	slot_data_t  data_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.flag_we) begin
			flag_mem[req.addr] <= req.flags;
		end
		rd_flags <= flag_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.data_we) begin
			data_mem[req.addr] <= wr_data;
		end
		rd_data <= data_mem[req.addr];
	end

endmodule

`default_nettype wire

/* src/hashed_handle_path_cache_unit.sv */
`default_nettype none

// Direct-mapped cache of path and info words keyed by an object handle (id, ts).
// Requests enter on the s_ group: s_tuser carries the action, s_tdata the handle
// and the payload words. Every request gives exactly one result on the m_ group:
// m_tuser is the found flag, m_tdata the info and path words (zero unless found).
// The slot is (1999*id + 3*sext(ts) + 5) mod 2^64 mod ENTRIES, worked out by one
// shared multiply-add that sums four 16-bit chunks with constant weights and then
// folds the sum below 2*ENTRIES, then one slot read and a write back for the writes.
// One request is in flight at a time: s_tready is high only while idle.
// m_tvalid rises once the request has passed the hash multiply and add steps,
// 4 accumulate steps and the fold steps, then the residue handoff, the slot read
// and the compare/write that loads the result. Actions 5 to 7 show their all-zero
// result in the cycle after they are taken.
// Invalidate all sweeps the flag memory one slot per cycle over all ENTRIES slots
// and then gives its all-zero result.
// After reset the same sweep runs with s_tready low.
// A result waits in its register while m_tready is low; no new request is taken
// until it has been delivered, and s_tready rises the cycle after delivery.

module hashed_handle_path_cache_unit
	import hhpc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// handle_id, handle_ts, path_ref, info_word (from bit 0 up)
	input  wire logic [S_DATA_W-1:0]     s_tdata,
	// action
	input  wire logic [ACT_W-1:0]        s_tuser,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// info_out, path_out (from bit 0 up)
	output logic [M_DATA_W-1:0]          m_tdata,
	// found
	output logic                         m_tuser
);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_HASH, S_RD, S_CMP, S_OUT} state_t;

	state_t                state_q;
	logic [SLOT_W-1:0]     clr_cnt_q;
	logic                  reply_q;
	action_t               action_q;
	logic [ID_W-1:0]       id_q;
	logic [TS_W-1:0]       ts_q;
	logic [PATH_WIDTH-1:0] path_q;
	logic [INFO_WIDTH-1:0] info_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  found_q;
	logic [INFO_WIDTH-1:0] info_out_q;
	logic [PATH_WIDTH-1:0] path_out_q;

	// request fields
	action_t               in_action;
	logic [ID_W-1:0]       in_id;
	logic [TS_W-1:0]       in_ts;
	logic [PATH_WIDTH-1:0] in_path;
	logic [INFO_WIDTH-1:0] in_info;
	logic                  req_acc;

	hash_req_t   hash_req;
	hash_rsp_t   hash_rsp;
	store_req_t  st_req;
	slot_data_t  wr_data;
	slot_flags_t rd_flags;
	slot_data_t  rd_data;
	logic        hit;

	assign in_action = action_t'(s_tuser);
	assign in_id     = s_tdata[ID_W-1:0];
	assign in_ts     = s_tdata[ID_W +: TS_W];
	assign in_path   = s_tdata[ID_W+TS_W +: PATH_WIDTH];
	assign in_info   = s_tdata[ID_W+TS_W+PATH_WIDTH +: INFO_WIDTH];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign req_acc  = s_tvalid && s_tready;

	assign m_tdata = M_DATA_W'({path_out_q, info_out_q});
	assign m_tuser = found_q;

	// hashing only for the four slot actions
	assign hash_req.start = req_acc && (in_action == ACT_STORE_PATH ||
		in_action == ACT_UPDATE_INFO || in_action == ACT_GET_INFO ||
		in_action == ACT_GET_PATH);
	assign hash_req.id = in_id;
	assign hash_req.ts = in_ts;

	hhpc_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hash_req),
		.rsp    (hash_rsp)
	);

	// tag hit, valid in S_CMP while read data is on the store outputs
	assign hit = rd_flags.valid && rd_data.tag_id == id_q && rd_data.tag_ts == ts_q;

	// slot write back and flag clear sweep; the tag is rewritten unchanged on a hit
	always_comb begin
		st_req.flag_we = 1'b0;
		st_req.data_we = 1'b0;
		st_req.addr    = slot_q;
		st_req.flags   = '0;
		wr_data.tag_id = id_q;
		wr_data.tag_ts = ts_q;
		wr_data.path   = path_q;
		wr_data.info   = rd_data.info;
		if (state_q == S_CLR) begin
			st_req.flag_we = 1'b1;
			st_req.addr    = clr_cnt_q;
		end else if (state_q == S_CMP) begin
			unique case (action_q)
				ACT_STORE_PATH: begin
					st_req.flag_we          = 1'b1;
					st_req.data_we          = 1'b1;
					st_req.flags.valid      = 1'b1;
					st_req.flags.path_valid = 1'b1;
					st_req.flags.info_valid = hit && rd_flags.info_valid;
				end
				ACT_UPDATE_INFO: begin
					st_req.flag_we          = 1'b1;
					st_req.data_we          = 1'b1;
					st_req.flags.valid      = 1'b1;
					st_req.flags.path_valid = hit && rd_flags.path_valid;
					st_req.flags.info_valid = 1'b1;
					wr_data.path            = hit ? rd_data.path : '0;
					wr_data.info            = info_q;
				end
				default: begin
				end
			endcase
		end
	end

	hhpc_store u_store (
		.clk      (clk),
		.req      (st_req),
		.wr_data  (wr_data),
		.rd_flags (rd_flags),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			reply_q   <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (clr_cnt_q == SLOT_W'(ENTRIES-1)) begin
						clr_cnt_q <= '0;
						state_q   <= reply_q ? S_OUT : S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						action_q   <= in_action;
						id_q       <= in_id;
						ts_q       <= in_ts;
						path_q     <= in_path;
						info_q     <= in_info;
						found_q    <= 1'b0;
						info_out_q <= '0;
						path_out_q <= '0;
						if (hash_req.start) begin
							state_q <= S_HASH;
						end else if (in_action == ACT_INVALIDATE) begin
							reply_q   <= 1'b1;
							clr_cnt_q <= '0;
							state_q   <= S_CLR;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_HASH: begin
					if (hash_rsp.done) begin
						slot_q  <= hash_rsp.slot;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					unique case (action_q)
						ACT_UPDATE_INFO: found_q <= hit;
						ACT_GET_INFO: begin
							found_q    <= hit && rd_flags.info_valid;
							info_out_q <= (hit && rd_flags.info_valid) ? rd_data.info : '0;
						end
						ACT_GET_PATH: begin
							found_q    <= hit && rd_flags.path_valid;
							path_out_q <= (hit && rd_flags.path_valid) ? rd_data.path : '0;
						end
						default: found_q <= 1'b0;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						reply_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// one request in flight: never ready for a request while a result is shown
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request accepted while result pending");

	// delivering a result frees the block for the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("not ready after result delivered");

	// invalidate starts a sweep: neither ready nor showing a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && in_action == ACT_INVALIDATE) |=> (!s_tready && !m_tvalid))
		else $error("invalidate did not start sweep");

	// a nonzero path word only comes back for get path
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && path_out_q != '0) |-> (action_q == ACT_GET_PATH && found_q))
		else $error("path word returned for wrong action");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

// Test of the handle-keyed path/info cache: a shadow copy of the slot array
// predicts each lookup result. Results are checked in order against it, while
// the sender and the receiver idle and stall at random.
module tb_top;
	import hhpc_pkg::*;

	// stream widths: fields packed from bit 0 up, rounded to whole bytes
	localparam int S_W = ((ID_W + TS_W + PATH_WIDTH + INFO_WIDTH + 7) / 8) * 8;
	localparam int M_W = ((INFO_WIDTH + PATH_WIDTH + 7) / 8) * 8;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int POOL_SIZE    = 24;
	localparam int SETTLE_CYC   = 64;

	typedef struct {
		logic [ACT_W-1:0]      action;
		logic [ID_W-1:0]       id;
		logic [TS_W-1:0]       ts;
		logic [PATH_WIDTH-1:0] path;
		logic [INFO_WIDTH-1:0] info;
	} cache_req_t;

	typedef struct {
		logic                  found;
		logic [INFO_WIDTH-1:0] info_out;
		logic [PATH_WIDTH-1:0] path_out;
	} lookup_rsp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_W-1:0]        s_tdata;
	logic [ACT_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_W-1:0]        m_tdata;
	logic                  m_tuser;

	hashed_handle_path_cache_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the slot array
	bit                  sh_valid   [ENTRIES];
	bit                  sh_path_ok [ENTRIES];
	bit                  sh_info_ok [ENTRIES];
	bit [ID_W-1:0]       sh_tag_id  [ENTRIES];
	bit [TS_W-1:0]       sh_tag_ts  [ENTRIES];
	bit [PATH_WIDTH-1:0] sh_path    [ENTRIES];
	bit [INFO_WIDTH-1:0] sh_info    [ENTRIES];

	lookup_rsp_t cache_rsp_q[$];

	// handles reused by the random traffic so that lookups hit
	logic [ID_W-1:0] pool_id [POOL_SIZE];
	logic [TS_W-1:0] pool_ts [POOL_SIZE];

	int n_err;
	int n_sent;
	int n_results;
	int n_update_hits;
	int n_gets_found;
	int n_invalidates;
	int n_unused;
	int n_collisions;
	int burst_left;
	int hold_left;
	int rx_mode;
	int rx_left;
	int rx_phase;
	int cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout watchdog
	initial begin
		for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [ID_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// (1999*id + 3*sext(ts) + 5) wraps at 64 bits, then mod ENTRIES
	function automatic int slot_index(logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
		logic [63:0] h;
		h = HASH_MUL * id + HASH_TS_MUL * {{(64-TS_W){ts[TS_W-1]}}, ts} + HASH_ADD;
		return int'(h % 64'(ENTRIES));
	endfunction

	// Predict one request and update the shadow copy.
	function automatic lookup_rsp_t cache_access(cache_req_t r);
		lookup_rsp_t rsp;
		int s;
		bit hit;
		rsp = '{found: 1'b0, info_out: '0, path_out: '0};
		s = slot_index(r.id, r.ts);
		hit = sh_valid[s] && sh_tag_id[s] == r.id && sh_tag_ts[s] == r.ts;
		case (r.action)
			ACT_STORE_PATH: begin
				if (!hit) begin
					sh_valid[s]   = 1'b1;
					sh_info_ok[s] = 1'b0;
					sh_tag_id[s]  = r.id;
					sh_tag_ts[s]  = r.ts;
				end
				sh_path_ok[s] = 1'b1;
				sh_path[s]    = r.path;
			end
			ACT_UPDATE_INFO: begin
				// a miss evicts the old slot and drops its path
				if (!hit) begin
					sh_valid[s]   = 1'b1;
					sh_path_ok[s] = 1'b0;
					sh_path[s]    = '0;
					sh_tag_id[s]  = r.id;
					sh_tag_ts[s]  = r.ts;
				end
				sh_info_ok[s] = 1'b1;
				sh_info[s]    = r.info;
				rsp.found     = hit;
				if (hit) n_update_hits++;
			end
			ACT_GET_INFO: begin
				if (hit && sh_info_ok[s]) begin
					rsp.found    = 1'b1;
					rsp.info_out = sh_info[s];
					n_gets_found++;
				end
			end
			ACT_GET_PATH: begin
				if (hit && sh_path_ok[s]) begin
					rsp.found    = 1'b1;
					rsp.path_out = sh_path[s];
					n_gets_found++;
				end
			end
			ACT_INVALIDATE: begin
				for (int i = 0; i < ENTRIES; i++) begin
					sh_valid[i]   = 1'b0;
					sh_path_ok[i] = 1'b0;
					sh_info_ok[i] = 1'b0;
					sh_tag_id[i]  = '0;
					sh_tag_ts[i]  = '0;
				end
				n_invalidates++;
			end
			default: begin
				// unused codes leave the cache alone and answer all zero
				n_unused++;
			end
		endcase
		return rsp;
	endfunction

	// Offer one request; bursts of back-to-back requests with random gaps between.
	// Called aligned to a rising edge; returns at the edge of acceptance.
	task automatic send_request(cache_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= r.action;
		s_tdata  <= S_W'({r.info, r.path, r.ts, r.id});
		do @(posedge clk); while (!s_tready);
		cache_rsp_q.push_back(cache_access(r));
		n_sent++;
	endtask

	// Lower valid and wait until every predicted result has come back.
	// Always returns at a later edge than the one it was called at.
	task automatic drain_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (cache_rsp_q.size() != 0) @(posedge clk);
	endtask

	function automatic cache_req_t make_req(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
			logic [TS_W-1:0] ts, logic [PATH_WIDTH-1:0] path, logic [INFO_WIDTH-1:0] info);
		cache_req_t r;
		r.action = act;
		r.id     = id;
		r.ts     = ts;
		r.path   = path;
		r.info   = info;
		return r;
	endfunction

	// Search for another handle that lands in the same slot.
	task automatic find_collider(input logic [ID_W-1:0] id, input logic [TS_W-1:0] ts,
			output logic [ID_W-1:0] id2, output logic [TS_W-1:0] ts2);
		int target;
		target = slot_index(id, ts);
		id2 = ~id;
		ts2 = ts;
		for (int k = 0; k < 50000; k++) begin
			id2 = rand64();
			ts2 = ($urandom_range(0, 1) == 0) ? ts : $urandom();
			if (slot_index(id2, ts2) == target && (id2 != id || ts2 != ts)) break;
		end
	endtask

	// Receiver: ready pattern changes mode every so often; a hold request
	// from a test forces a long stall counted here.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 200);
				end
				rx_left--;
				rx_phase++;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_phase % 5) < 3;
				endcase
			end
		end
	end

	// Result checker: compare every delivered result with the oldest prediction.
	always @(posedge clk) begin : check_results
		lookup_rsp_t want;
		logic [INFO_WIDTH-1:0] got_info;
		logic [PATH_WIDTH-1:0] got_path;
		if (arst_n && m_tvalid && m_tready) begin
			got_info = m_tdata[0 +: INFO_WIDTH];
			got_path = m_tdata[INFO_WIDTH +: PATH_WIDTH];
			if (cache_rsp_q.size() == 0) begin
				$error("result with no request outstanding: found=%0d info=%h path=%h",
					m_tuser, got_info, got_path);
				n_err++;
			end else begin
				want = cache_rsp_q.pop_front();
				n_results++;
				if (m_tuser !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, m_tuser);
					n_err++;
				end
				if (got_info !== want.info_out) begin
					$error("info_out: expected %h, actual %h", want.info_out, got_info);
					n_err++;
				end
				if (got_path !== want.path_out) begin
					$error("path_out: expected %h, actual %h", want.path_out, got_path);
					n_err++;
				end
			end
		end
	end

	// Corner handles and payloads, every action, hit/miss on both writes,
	// a get of a payload whose valid bit is clear, unused codes, invalidate.
	task automatic test_directed_corners();
		logic [ID_W-1:0] ones;
		ones = '1;
		send_request(make_req(ACT_GET_PATH, '0, '0, '1, '1));
		send_request(make_req(ACT_STORE_PATH, '0, '0, '1, '1));
		send_request(make_req(ACT_GET_PATH, '0, '0, '0, '0));
		// path stored but info never written
		send_request(make_req(ACT_GET_INFO, '0, '0, '0, '0));
		send_request(make_req(ACT_UPDATE_INFO, '0, '0, '0, ones));
		send_request(make_req(ACT_GET_INFO, '0, '0, '1, '0));
		send_request(make_req(ACT_STORE_PATH, ones, 32'h8000_0000, '0, '1));
		send_request(make_req(ACT_GET_PATH, ones, 32'hffff_ffff, '0, '0));
		// update miss: new tag, path dropped
		send_request(make_req(ACT_UPDATE_INFO, ones, 32'h7fff_ffff, '1, '0));
		send_request(make_req(ACT_GET_PATH, ones, 32'h7fff_ffff, '0, '0));
		send_request(make_req(ACT_GET_INFO, ones, 32'h7fff_ffff, '0, '0));
		send_request(make_req(ACT_UPDATE_INFO, '0, '0, '0, 64'ha5a5_5a5a_0ff0_f00f));
		// store hit keeps info valid
		send_request(make_req(ACT_STORE_PATH, '0, '0, 32'h5a5a_a5a5, '0));
		send_request(make_req(ACT_GET_INFO, '0, '0, '0, '0));
		send_request(make_req(3'd5, rand64(), $urandom(), $urandom(), rand64()));
		send_request(make_req(3'd6, '1, '1, '1, '1));
		send_request(make_req(3'd7, '0, '0, '0, '0));
		send_request(make_req(ACT_INVALIDATE, rand64(), $urandom(), $urandom(), rand64()));
		send_request(make_req(ACT_GET_PATH, '0, '0, '0, '0));
		send_request(make_req(ACT_GET_INFO, ones, 32'h7fff_ffff, '0, '0));
		drain_results();
	endtask

	// Two handles sharing a slot evict each other.
	task automatic test_slot_collisions();
		logic [ID_W-1:0] id_a, id_b;
		logic [TS_W-1:0] ts_a, ts_b;
		id_a = rand64();
		ts_a = $urandom();
		find_collider(id_a, ts_a, id_b, ts_b);
		send_request(make_req(ACT_STORE_PATH, id_a, ts_a, $urandom(), rand64()));
		send_request(make_req(ACT_STORE_PATH, id_b, ts_b, $urandom(), rand64()));
		send_request(make_req(ACT_GET_PATH, id_a, ts_a, '0, '0));
		send_request(make_req(ACT_GET_PATH, id_b, ts_b, '0, '0));
		send_request(make_req(ACT_UPDATE_INFO, id_a, ts_a, '0, rand64()));
		send_request(make_req(ACT_GET_PATH, id_b, ts_b, '0, '0));
		drain_results();
	endtask

	task automatic fill_handle_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i % 4 == 3) begin
				find_collider(pool_id[i-1], pool_ts[i-1], pool_id[i], pool_ts[i]);
				n_collisions++;
			end else begin
				pool_id[i] = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(0, 9))
					: rand64();
				pool_ts[i] = ($urandom_range(0, 2) == 0) ? TS_W'($urandom_range(0, 6) - 3)
					: $urandom();
			end
		end
	endtask

	function automatic cache_req_t random_req(bit allow_rare);
		cache_req_t r;
		int p;
		int k;
		p = $urandom_range(0, 99);
		if (!allow_rare && p >= 98) p = p - 2;
		if (p < 27)       r.action = ACT_STORE_PATH;
		else if (p < 54)  r.action = ACT_UPDATE_INFO;
		else if (p < 76)  r.action = ACT_GET_INFO;
		else if (p < 98)  r.action = ACT_GET_PATH;
		else if (p == 98) r.action = ACT_INVALIDATE;
		else              r.action = ACT_W'($urandom_range(5, 7));
		if ($urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, POOL_SIZE - 1);
			r.id = pool_id[k];
			r.ts = pool_ts[k];
		end else begin
			r.id = rand64();
			r.ts = $urandom();
		end
		r.path = $urandom();
		r.info = rand64();
		return r;
	endfunction

	// Receiver holds off long while the sender keeps offering: input must stall.
	task automatic test_backpressure_fill();
		drain_results();
		hold_left = 300;
		for (int i = 0; i < 12; i++) send_request(random_req(1'b0));
		drain_results();
	endtask

	// Mostly pool handles so that hits, evictions and refills dominate.
	task automatic test_random_traffic();
		cache_req_t r;
		int counted;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = random_req(1'b1);
			send_request(r);
			if (r.action <= ACT_INVALIDATE) counted++;
			// occasionally let everything settle before going on
			if ($urandom_range(0, 199) == 0) drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_slot_collisions();
		fill_handle_pool();
		test_backpressure_fill();
		test_random_traffic();
		test_backpressure_fill();
		drain_results();
		repeat (SETTLE_CYC) @(posedge clk);
		$display("Run covered %0d requests, %0d results checked, %0d errors.",
			n_sent, n_results, n_err);
		$display("Update hits %0d, gets found %0d, invalidates %0d, unused codes %0d.",
			n_update_hits, n_gets_found, n_invalidates, n_unused);
		if (n_err == 0 && cache_rsp_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
